// File: rtl/msdg_pkg.sv
package msdg_pkg;

  // Command codes carried in the input tuser field.
  typedef enum logic [3:0] {
    KIND_TICK        = 4'd0,
    KIND_SET_TARGET  = 4'd1,
    KIND_ZERO        = 4'd2,
    KIND_STOP_AXIS   = 4'd3,
    KIND_STOP_ALL    = 4'd4,
    KIND_ENABLE_AXIS = 4'd5,
    KIND_DISABLE_AXIS = 4'd6,
    KIND_DISABLE_ALL = 4'd7,
    KIND_ENABLE_ALL  = 4'd8
  } kind_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_PERIOD_X   = 3'd0;
  localparam logic [2:0] REG_DIR_MASK   = 3'd5;
  localparam int         NUM_PERIOD_REGS = 5;

  // Reset periods of the programmable axes; further axes run at PERIOD_FIXED.
  localparam int unsigned PERIOD_RESET [NUM_PERIOD_REGS] = '{10, 30, 50, 100, 100};
  localparam int unsigned PERIOD_FIXED   = 100;
  localparam int unsigned DIR_MASK_RESET = 29;

  // Field widths at the ports.
  localparam int MASK_W     = 5;
  localparam int POS_W      = 24;
  localparam int CFG_DATA_W = 16;

endpackage

// File: rtl/multi_axis_step_dir_generator.sv
// Constant-speed step/direction generator for up to eight axes. Every input
// transfer (a tick or a command) produces exactly one result transfer that
// reports the step, direction and enable line levels, the moving mask and
// the position of the addressed axis in whole steps. One shared axis unit
// visits the axes one per clock, first to update them and then to gather the
// moving mask and position. s_axis_tready is low from the acceptance of an
// input transfer until its result is written to the output register, and that
// write waits while the previous result has not yet left on m_axis_tready.
// A finished result sits in the output register, so the next input transfer
// can be taken before the result is collected. Configuration writes are taken
// at any time but should only be issued while no item is in flight.
module multi_axis_step_dir_generator #(
  parameter int AXES          = 5,
  parameter int PERIOD_BITS   = 16,
  parameter int POSITION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // axis[2:0], target_steps[26:3], paused[27]
  input  logic [3:0]  s_axis_tuser,   // kind[3:0]
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // step_lines[4:0], dir_lines[9:5],
                                      // enable_lines[14:10], moving_mask[19:15],
                                      // position_steps[43:20]
);

  localparam int HB    = POSITION_BITS + 1;
  localparam int PB    = PERIOD_BITS;
  localparam int IDX_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int OW    = (AXES > msdg_pkg::MASK_W) ? AXES : msdg_pkg::MASK_W;
  localparam int TW    = (POSITION_BITS > msdg_pkg::POS_W) ? POSITION_BITS : msdg_pkg::POS_W;
  localparam int CW    = (PB > msdg_pkg::CFG_DATA_W) ? PB : msdg_pkg::CFG_DATA_W;
  localparam logic [OW-1:0] DIR_RST_W = OW'(msdg_pkg::DIR_MASK_RESET);

  typedef enum logic [1:0] {S_IDLE, S_UPD, S_CHK, S_DONE} state_t;

  state_t state;

  // Item being worked on.
  logic [3:0]               kind_q;
  logic [2:0]               axis_q;
  logic [POSITION_BITS-1:0] target_q;
  logic                     paused_q;
  logic [IDX_W-1:0]         idx;

  // Axis state.
  logic signed [HB-1:0] cur [AXES];
  logic signed [HB-1:0] tgt [AXES];
  logic [PB-1:0]        cd  [AXES];
  logic [PB-1:0]        period [AXES];
  logic [AXES-1:0]      armed;
  logic [AXES-1:0]      step_levels;
  logic [AXES-1:0]      dir_levels;
  logic [AXES-1:0]      enabled;
  logic [AXES-1:0]      pos_dir_mask;
  logic [AXES-1:0]      moving_q;
  logic [POSITION_BITS-1:0] pos_q;

  // Configuration.
  logic [CW-1:0]  cfg_wide;
  logic [PB-1:0]  cfg_period;
  logic [OW-1:0]  cfg_mask_w;

  assign cfg_wide   = CW'(cfg_data);
  assign cfg_period = cfg_wide[PB-1:0];
  assign cfg_mask_w = OW'(cfg_data[msdg_pkg::MASK_W-1:0]);

  for (genvar a = 0; a < AXES; a++) begin : g_period
    if (a < msdg_pkg::NUM_PERIOD_REGS) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          period[a] <= PB'(msdg_pkg::PERIOD_RESET[a]);
        end else if (cfg_wr_en && cfg_index == 3'(msdg_pkg::REG_PERIOD_X + a)) begin
          period[a] <= cfg_period;
        end
      end
    end else begin : g_fixed
      assign period[a] = PB'(msdg_pkg::PERIOD_FIXED);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_dir_mask <= DIR_RST_W[AXES-1:0];
    end else if (cfg_wr_en && cfg_index == msdg_pkg::REG_DIR_MASK) begin
      pos_dir_mask <= cfg_mask_w[AXES-1:0];
    end
  end

  // Shared axis unit: works on the axis selected by idx.
  logic signed [HB-1:0] cur_a, tgt_a, tgt_in, tgt_dec, cur_n, tgt_n, half_sum;
  logic [PB-1:0]        cd_a, cd_n, per_a;
  logic                 arm_a, arm_n, stp_n, dir_n, en_n;
  logic                 hit, dec, gt, eq;

  assign cur_a   = cur[idx];
  assign tgt_a   = tgt[idx];
  assign cd_a    = cd[idx];
  assign per_a   = period[idx];
  assign arm_a   = armed[idx];
  assign hit     = ({1'b0, axis_q} < 4'(AXES)) && (axis_q == 3'(idx));
  assign tgt_in  = {target_q, 1'b0};
  assign tgt_dec = (kind_q == msdg_pkg::KIND_SET_TARGET) ? tgt_in : tgt_a;
  assign gt      = tgt_dec > cur_a;
  assign eq      = tgt_dec == cur_a;
  // Rounds toward zero: negative odd values are pulled up before the shift.
  assign half_sum = cur_a + HB'(cur_a[HB-1]);

  always_comb begin
    cur_n = cur_a;
    tgt_n = tgt_a;
    cd_n  = cd_a;
    arm_n = arm_a;
    stp_n = step_levels[idx];
    dir_n = dir_levels[idx];
    en_n  = enabled[idx];
    dec   = 1'b0;
    unique case (kind_q)
      msdg_pkg::KIND_TICK: begin
        if (arm_a) begin
          if (cd_a[PB-1:1] == '0) begin
            cd_n = '0;
            dec  = 1'b1;
          end else begin
            cd_n = cd_a - PB'(1);
          end
        end
      end
      msdg_pkg::KIND_SET_TARGET: begin
        if (hit) begin
          tgt_n = tgt_in;
          dec   = 1'b1;
        end
      end
      msdg_pkg::KIND_ZERO: begin
        if (hit) begin
          cur_n = '0;
          tgt_n = '0;
        end
      end
      msdg_pkg::KIND_STOP_AXIS: begin
        if (hit) tgt_n = cur_a;
      end
      msdg_pkg::KIND_STOP_ALL: begin
        tgt_n = cur_a;
      end
      msdg_pkg::KIND_ENABLE_AXIS: begin
        if (hit) en_n = 1'b1;
      end
      msdg_pkg::KIND_DISABLE_AXIS: begin
        if (hit) en_n = 1'b0;
      end
      msdg_pkg::KIND_DISABLE_ALL: begin
        tgt_n = cur_a;
        en_n  = 1'b0;
      end
      msdg_pkg::KIND_ENABLE_ALL: begin
        en_n = 1'b1;
      end
      default: ;
    endcase
    if (dec) begin
      if (!paused_q && eq) begin
        arm_n = 1'b0;
      end else begin
        if (!paused_q) begin
          dir_n = (gt == pos_dir_mask[idx]);
          stp_n = ~stp_n;
          cur_n = cur_a + {{(HB-1){~gt}}, 1'b1};
        end
        cd_n  = per_a;
        arm_n = 1'b1;
      end
    end
  end

  // Output field formatting.
  logic [OW-1:0] step_w, dir_w, en_w, mov_w;
  logic [TW-1:0] pos_w;

  assign step_w = OW'(step_levels);
  assign dir_w  = OW'(dir_levels);
  assign en_w   = OW'(enabled);
  assign mov_w  = OW'(moving_q);
  assign pos_w  = TW'(pos_q);

  assign s_axis_tready = (state == S_IDLE);

  logic [TW-1:0] tin_w;
  assign tin_w = TW'(s_axis_tdata[26:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      m_axis_tvalid <= 1'b0;
      armed         <= '0;
      step_levels   <= '0;
      dir_levels    <= '0;
      enabled       <= '0;
      for (int i = 0; i < AXES; i++) begin
        cur[i] <= '0;
        tgt[i] <= '0;
        cd[i]  <= '0;
      end
    end else begin
      // In S_DONE the output register is refilled instead.
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            kind_q   <= s_axis_tuser;
            axis_q   <= s_axis_tdata[2:0];
            target_q <= tin_w[POSITION_BITS-1:0];
            paused_q <= s_axis_tdata[27];
            pos_q    <= '0;
            idx      <= '0;
            state    <= S_UPD;
          end
        end
        S_UPD: begin
          cur[idx]         <= cur_n;
          tgt[idx]         <= tgt_n;
          cd[idx]          <= cd_n;
          armed[idx]       <= arm_n;
          step_levels[idx] <= stp_n;
          dir_levels[idx]  <= dir_n;
          enabled[idx]     <= en_n;
          if (idx == IDX_W'(AXES - 1)) begin
            idx   <= '0;
            state <= S_CHK;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_CHK: begin
          moving_q[idx] <= (cur_a != tgt_a);
          if (hit) pos_q <= half_sum[HB-1:1];
          if (idx == IDX_W'(AXES - 1)) begin
            idx   <= '0;
            state <= S_DONE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {4'b0, pos_w[msdg_pkg::POS_W-1:0],
                              mov_w[msdg_pkg::MASK_W-1:0], en_w[msdg_pkg::MASK_W-1:0],
                              dir_w[msdg_pkg::MASK_W-1:0], step_w[msdg_pkg::MASK_W-1:0]};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A new item is never taken in the cycle after one was accepted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // Line levels only move while an item is being processed.
  a_lines_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && !s_axis_tvalid |=> $stable(step_levels) && $stable(dir_levels))
    else $error("step or direction lines changed while idle");

  // The axis walk always starts from the first axis.
  a_idx_home: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> idx == '0)
    else $error("axis index not at zero outside the walk");

endmodule
